// ===== rtl/sha256_pkg.sv =====
// SHA-256 hasher package: payload structs, round constants, a rotate helper,
// and the controller-to-datapath command/status structs. No dependencies.
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        BSRC_IDLE,
        BSRC_DATA,
        BSRC_PAD80,
        BSRC_ZERO,
        BSRC_LEN
    } byte_src_t;

    typedef struct packed {
        logic       clear_msg;   // reset hash words and byte count
        logic       byte_write;  // shift one byte into the block buffer
        byte_src_t  byte_src;
        logic       count_up;
        logic       round_init;  // load working vars and schedule
        logic       round_step;  // one round
        logic       hash_add;    // fold working vars into hash words
        logic       out_load;    // load digest word word_sel into output reg
        logic [2:0] word_sel;
        logic [5:0] round_idx;
        logic [2:0] len_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] byte_pos;    // byte count mod 64
    } dp_status_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/sha256_dp.sv =====
// SHA-256 datapath: block shift buffer, rolling 16-word schedule, working
// variables, chained hash words, byte counter, output register. Uses sha256_pkg.
module sha256_dp
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [7:0]  data_byte,
    output dp_status_t  status,
    output out_item_t   out_item
);

    logic [7:0]  blk_reg [64];
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [60:0] count_reg;
    out_item_t   out_reg;

    logic [7:0]  byte_in;
    logic [63:0] bits;
    logic [31:0] w_new, wi, t1, t2, s0, s1, w15, w2;

    assign bits = {count_reg, 3'b000};

    always_comb
    begin
        case (cmd.byte_src)
            BSRC_DATA:  byte_in = data_byte;
            BSRC_PAD80: byte_in = PAD_BYTE;
            BSRC_LEN:   byte_in = bits[8*(7-cmd.len_idx) +: 8];
            default:    byte_in = 8'h00;
        endcase
    end

    // Schedule: window w_reg[0] is W[t], rolls left each round.
    assign w15 = w_reg[1];
    assign w2  = w_reg[14];
    assign s0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
    assign s1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;
    assign wi  = w_reg[0];

    assign t1 = v_reg[7] + (ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[cmd.round_idx] + wi;
    assign t2 = (ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_ff @(posedge clk)
    begin
        if (cmd.byte_write)
        begin
            for (int i = 0; i < 63; i++)
                blk_reg[i] <= blk_reg[i+1];
            blk_reg[63] <= byte_in;
        end
        if (cmd.round_init)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= {blk_reg[4*i], blk_reg[4*i+1], blk_reg[4*i+2], blk_reg[4*i+3]};
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (cmd.out_load)
        begin
            out_reg.digest_word <= h_reg[cmd.word_sel];
            out_reg.word_index  <= cmd.word_sel;
            out_reg.last_word   <= (cmd.word_sel == 3'd7);
        end
    end

    // The schedule window holds W[t..t+15]; entries beyond round 47 are
    // never used, so computing them is harmless.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= INIT_HASH[i];
            count_reg <= '0;
        end
        else
        begin
            if (cmd.clear_msg)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= INIT_HASH[i];
                count_reg <= '0;
            end
            else
            begin
                if (cmd.hash_add)
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                if (cmd.count_up)
                    count_reg <= count_reg + 61'd1;
            end
        end
    end

    assign status.byte_pos = count_reg[5:0];
    assign out_item = out_reg;

endmodule

// ===== rtl/sha256_ctrl.sv =====
// SHA-256 controller: sequences byte intake, padding, 64 rounds per block
// and the eight-word digest output. Uses sha256_pkg.
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   in_item,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_LEN,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] pos_reg, pos_next;   // padding write position
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;   // length byte or digest word
    logic       fin_reg, fin_next;   // padding pending after block
    logic       last_reg, last_next; // final block of the message
    logic       ov_reg, ov_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        last_next  = last_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        cmd.byte_src  = BSRC_IDLE;
        cmd.round_idx = rnd_reg;
        cmd.len_idx   = idx_reg;
        cmd.word_sel  = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fin_next  = in_item.end_of_message;
                    last_next = 1'b0;
                    pos_next  = status.byte_pos;
                    if (in_item.byte_valid)
                    begin
                        cmd.byte_write = 1'b1;
                        cmd.byte_src   = BSRC_DATA;
                        cmd.count_up   = 1'b1;
                        pos_next       = status.byte_pos + 6'd1;
                        if (status.byte_pos == 6'd63)
                            state_next = S_INIT;
                        else if (in_item.end_of_message)
                            state_next = S_PAD;
                    end
                    else if (in_item.end_of_message)
                        state_next = S_PAD;
                    if (state_next == S_PAD)
                    begin
                        // 0x80 is written first, in S_PAD
                        state_next = S_PAD;
                        fin_next   = 1'b0;
                    end
                end
            end
            S_PAD:
            begin
                // entered with pos_reg = next write position; 0x80 pending
                // is encoded by idx_reg==0, zeros follow once idx_reg==1
                cmd.byte_write = 1'b1;
                cmd.byte_src   = (idx_reg == 3'd1) ? BSRC_ZERO : BSRC_PAD80;
                idx_next       = 3'd1;
                pos_next       = pos_reg + 6'd1;
                if (pos_reg == 6'd63)
                begin
                    idx_next   = 3'd1;
                    state_next = S_INIT;
                end
                else if (pos_reg == LEN_POS - 6'd1)
                begin
                    idx_next   = '0;
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                cmd.byte_write = 1'b1;
                cmd.byte_src   = BSRC_LEN;
                idx_next       = idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    last_next  = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.round_init = 1'b1;
                rnd_next       = '0;
                state_next     = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                rnd_next       = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.hash_add = 1'b1;
                if (last_reg)
                begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
                else if (fin_reg)
                begin
                    // message ended exactly on a block boundary
                    fin_next   = 1'b0;
                    idx_next   = '0;
                    pos_next   = '0;
                    state_next = S_PAD;
                end
                else if (pos_reg != '0)
                    state_next = S_PAD;   // pad spill: continue with zeros
                else
                    state_next = S_IDLE;
                if (!last_reg && !fin_reg && pos_reg != '0)
                    idx_next = 3'd1;
                if (!last_reg && !fin_reg && pos_reg == '0 && idx_reg == 3'd1)
                begin
                    // padding spilled into a new block: zeros up to length
                    state_next = S_PAD;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    idx_next     = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.clear_msg = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (ov_reg && out_ready && !cmd.out_load)
            ov_next = 1'b0;
        // idx of 0 marks "0x80 still pending" when entering padding from IDLE
        if (state_reg == S_IDLE)
            idx_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            last_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            last_reg  <= last_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// SHA-256 byte-stream hasher top level: joins controller and datapath.
// Depends on sha256_pkg, sha256_ctrl, sha256_dp.
//
// Takes a message one byte per transaction; a transaction with
// end_of_message set (with or without a byte) pads the message, finishes it
// and delivers the digest as eight transactions, word 0 first, then restarts
// at the initial hash values. The 64th byte of a block starts a
// compression (load, 64 rounds, add), during which no input is taken,
// since a single round unit does all rounds in turn. A message end
// writes the padding (spilling into a second block when the pad byte
// lands in the last eight bytes of a block), runs one or two
// compressions, then delivers eight output words paced by out_ready.
// Input is taken only while the controller idles.
module sha256_byte_stream_hasher
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence intake, padding, rounds and output.
    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the block, schedule, working and hash words.
    sha256_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (in_data.data_byte),
        .status    (status),
        .out_item  (out_data)
    );

endmodule

// ===== tb/sv/sha256_stream_checker.sv =====
`timescale 1ns / 100ps
// Digest checker for the SHA-256 byte-stream hasher: watches both channels,
// computes expected digest words and compares them. Depends on sha256_pkg.
module sha256_stream_checker
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending_words,
    output int        digests_seen
);

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    logic [60:0] nbytes;
    out_item_t   digest_q [$];

    function automatic logic [31:0] rr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] t1, t2, w15, w2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        v = chain;
        for (int i = 0; i < 64; i++)
        begin
            if (i >= 16)
            begin
                w15 = w[(i + 1) & 15];
                w2 = w[(i + 14) & 15];
                w[i & 15] += (rr(w15, 7) ^ rr(w15, 18) ^ (w15 >> 3)) + w[(i + 9) & 15]
                             + (rr(w2, 17) ^ rr(w2, 19) ^ (w2 >> 10));
            end
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i & 15];
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += v[i];
    endtask

    // Fold one accepted transaction into the running hash; an end of message also pads, finishes and queues the digest.
    task automatic absorb(input in_item_t it);
        int p;
        logic [63:0] bits;
        out_item_t o;
        if (it.byte_valid)
        begin
            p = nbytes[5:0];
            blk[p] = it.data_byte;
            nbytes = nbytes + 1'b1;
            if (p == 63)
                compress();
        end
        if (!it.end_of_message)
            return;
        bits = {nbytes, 3'b000};
        p = nbytes[5:0];
        blk[p] = PAD_BYTE;
        p++;
        if (p > 56)
        begin
            for (int k = p; k < 64; k++)
                blk[k] = 8'h00;
            compress();
            p = 0;
        end
        for (int k = p; k < 56; k++)
            blk[k] = 8'h00;
        for (int i = 0; i < 8; i++)
            blk[56 + i] = bits[63 - 8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            o.digest_word = chain[i];
            o.word_index = 3'(i);
            o.last_word = (i == 7);
            digest_q = {digest_q, o};
        end
        chain = INIT_HASH;
        nbytes = '0;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            fail_count = 0;
            digests_seen = 0;
            chain = INIT_HASH;
            nbytes = '0;
            foreach (blk[i]) blk[i] = 8'h00;
            digest_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                absorb(in_data);
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                    report("unexpected word", out_data.digest_word, 32'h0);
                else
                begin
                    e = digest_q.pop_front();
                    if (out_data.digest_word !== e.digest_word)
                        report("digest_word", out_data.digest_word, e.digest_word);
                    if (out_data.word_index !== e.word_index)
                        report("word_index", 32'(out_data.word_index), 32'(e.word_index));
                    if (out_data.last_word !== e.last_word)
                        report("last_word", 32'(out_data.last_word), 32'(e.last_word));
                    if (out_data.last_word)
                        digests_seen++;
                end
            end
        end
        pending_words = digest_q.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Top of the SHA-256 byte-stream hasher testbench: clock, reset, stimulus
// and verdict. Depends on sha256_pkg and sha256_stream_checker.
module tb
    import sha256_pkg::*;
();

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        fail_count;
    int        pending_words;
    int        digests_seen;
    int        sent_items;
    int        msg_count;
    bit        hold_off_req;   // ask the receiver for one long stall

    sha256_byte_stream_hasher uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    sha256_stream_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending_words(pending_words),
        .digests_seen(digests_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offer one transaction after a random gap; hold it until accepted.
    // With gaps off the sender keeps valid high across back-to-back items.
    task automatic send(input logic [7:0] b, input bit bv, input bit eom, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_byte: b, byte_valid: bv, end_of_message: eom};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
        if (eom)
            msg_count++;
        @(negedge clk);
    endtask

    // One message of n random bytes; the end may ride on the last byte.
    task automatic send_message(input int n, input bit fast);
        bit fold;
        fold = (n > 0) && $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
            send(8'($urandom), 1'b1, fold && (i == n - 1), fast);
        if (!fold)
            send(8'($urandom), 1'b0, 1'b1, fast);
    endtask

    task automatic idle_until_drained();
        in_valid <= 1'b0;
        while (pending_words != 0)
            @(negedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int gap;
        bit held;
        out_ready = 1'b0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !held)
            begin
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                held = 1;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int n;
        int waited;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        sent_items = 0;
        msg_count = 0;
        hold_off_req = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty message, byte riding on the end, field extremes,
        // a no-op transaction that must change nothing.
        send(8'h00, 1'b0, 1'b1, 1'b0);
        send(8'hff, 1'b0, 1'b0, 1'b0);
        send(8'hff, 1'b1, 1'b1, 1'b0);
        send(8'h00, 1'b1, 1'b0, 1'b0);
        send(8'h55, 1'b0, 1'b0, 1'b0);
        send(8'haa, 1'b1, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b1, 1'b0);
        // Pause until all digest words are back.
        idle_until_drained();

        // Pad boundaries: lengths 55 and 56 in back-to-back bursts.
        send_message(55, 1'b1);
        send_message(56, 1'b1);
        idle_until_drained();

        // Long receiver stall while the sender keeps offering messages.
        hold_off_req = 1;
        send_message(0, 1'b1);
        send_message(3, 1'b1);
        send_message(64, 1'b1);
        idle_until_drained();

        // Random messages, mostly short, with sparse no-op noise.
        while (sent_items < 280)
        begin
            if ($urandom_range(0, 9) == 0)
                send(8'($urandom), 1'b0, 1'b0, 1'b0);
            else
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(57, 130)
                                                : $urandom_range(0, 20);
                send_message(n, $urandom_range(0, 3) == 0);
            end
        end
        in_valid <= 1'b0;

        waited = 0;
        while (pending_words != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (200) @(negedge clk);

        $display("Hashed %0d messages over %0d transactions, %0d digests checked.",
                 msg_count, sent_items, digests_seen);
        $display("Covered empty, pad-boundary, multi-block and stalled-output cases.");
        if (fail_count == 0 && pending_words == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
